[rtl/pdw_pkg.sv]
// Shared types and constants for the positional PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pdw_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAIN_P       = 3'd0;
  localparam logic [2:0] CFG_GAIN_I       = 3'd1;
  localparam logic [2:0] CFG_GAIN_D       = 3'd2;
  localparam logic [2:0] CFG_DEADBAND     = 3'd3;
  localparam logic [2:0] CFG_OUTPUT_LIMIT = 3'd4;
  localparam logic [2:0] CFG_WRAP_ENABLE  = 3'd5;

  // Field widths.
  localparam int unsigned GAIN_W  = 25;
  localparam int unsigned DB_W    = 20;
  localparam int unsigned LIMIT_W = 31;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]  RST_GAIN_P       = 25'd14581760;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I       = 25'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D       = 25'd14149222;
  localparam logic [DB_W-1:0]    RST_DEADBAND     = 20'd19661;
  localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT = 31'd133169152;

  // Angle fold thresholds in Q15.16: 180 and 360 degrees.
  localparam logic signed [31:0] HALF_TURN = 32'sd11796480;
  localparam logic signed [31:0] FULL_TURN = 32'sd23592960;

  // Rounding offset for the Q.32 to Q.16 step.
  localparam logic [63:0] ROUND_HALF = 64'd32768;

  // Load strobes for the five pipeline registers.
  typedef struct packed {
    logic a;  // error formed and folded
    logic b;  // deadband applied, state updated
    logic c;  // products
    logic d;  // integral term combined and saturated
    logic e;  // rounded, clamped result
  } pdw_adv_t;

endpackage

`default_nettype wire

[rtl/pdw_err.sv]
// Error path: saturated error, angle fold, deadband, integral and derivative state.
`timescale 1ns / 1ps
`default_nettype none

module pdw_err #(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  wire                   clk,
  input  wire                   rst,
  input  pdw_pkg::pdw_adv_t     adv,
  input  wire  [31:0]           setpoint,
  input  wire  [31:0]           measured,
  input  wire                   wrap_enable,
  input  wire  [pdw_pkg::DB_W-1:0] deadband,
  output logic [31:0]           err_b,
  output logic [SUM_WIDTH-1:0]  sum_b,
  output logic [32:0]           diff_b
);
  import pdw_pkg::*;

  logic [32:0]          raw_diff;
  logic [31:0]          err_sat;
  logic [31:0]          err_fold;
  logic [31:0]          err_a;
  logic [32:0]          err_a33;
  logic signed [32:0]   db_pos;
  logic signed [32:0]   db_neg;
  logic [31:0]          err_used;
  logic [SUM_WIDTH:0]   sum_wide;
  logic [SUM_WIDTH-1:0] sum_next;
  logic [SUM_WIDTH-1:0] error_sum;
  logic [31:0]          previous_error;

  // Saturating subtraction of the measurement from the target.
  assign raw_diff = {setpoint[31], setpoint} - {measured[31], measured};
  always_comb begin
    if (raw_diff[32] != raw_diff[31]) begin
      err_sat = raw_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      err_sat = raw_diff[31:0];
    end
  end

  // With wrap enabled, a single fold by a full turn when the error lies beyond half a turn.
  always_comb begin
    err_fold = err_sat;
    if (wrap_enable) begin
      if ($signed(err_sat) > HALF_TURN) begin
        err_fold = err_sat - FULL_TURN;
      end else if ($signed(err_sat) < -HALF_TURN) begin
        err_fold = err_sat + FULL_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.a) begin
      err_a <= err_fold;
    end
  end

  // Errors inside the deadband become zero.
  assign err_a33 = {err_a[31], err_a};
  assign db_pos  = $signed({13'd0, deadband});
  assign db_neg  = -db_pos;
  always_comb begin
    if (($signed(err_a33) <= db_pos) && ($signed(err_a33) >= db_neg)) begin
      err_used = '0;
    end else begin
      err_used = err_a;
    end
  end

  // Saturating integral update.
  assign sum_wide = {error_sum[SUM_WIDTH-1], error_sum}
                  + {{(SUM_WIDTH + 1 - 32){err_used[31]}}, err_used};
  always_comb begin
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH - 1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH - 1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // Controller state advances once per item.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (adv.b) begin
      error_sum      <= sum_next;
      previous_error <= err_used;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.b) begin
      err_b  <= err_used;
      sum_b  <= sum_next;
      diff_b <= {err_used[31], err_used} - {previous_error[31], previous_error};
    end
  end

endmodule

`default_nettype wire

[rtl/pdw_mult.sv]
// Gain products and the saturated integral term.
`timescale 1ns / 1ps
`default_nettype none

module pdw_mult #(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  wire                        clk,
  input  pdw_pkg::pdw_adv_t          adv,
  input  wire  [pdw_pkg::GAIN_W-1:0] gain_p,
  input  wire  [pdw_pkg::GAIN_W-1:0] gain_i,
  input  wire  [pdw_pkg::GAIN_W-1:0] gain_d,
  input  wire  [31:0]                err_b,
  input  wire  [SUM_WIDTH-1:0]       sum_b,
  input  wire  [32:0]                diff_b,
  output logic [62:0]                iterm_d,
  output logic [59:0]                pd_d,
  output logic [31:0]                err_d
);
  import pdw_pkg::*;

  // High part of the integral split: signed upper bits times the gain.
  localparam int unsigned HI_W   = SUM_WIDTH - 32 + GAIN_W + 1;
  localparam int unsigned FULL_W = HI_W + 32;
  localparam int unsigned LO_W   = 32 + GAIN_W;

  logic signed [57:0]   p_prod;
  logic signed [58:0]   d_prod;
  logic [LO_W-1:0]      lo_prod;
  logic signed [HI_W-1:0] hi_prod;
  logic [57:0]          p_c;
  logic [58:0]          d_c;
  logic [LO_W-1:0]      lo_c;
  logic [HI_W-1:0]      hi_c;
  logic [31:0]          err_c;
  logic signed [FULL_W-1:0] full_i;
  logic signed [FULL_W-1:0] cap_pos;
  logic signed [FULL_W-1:0] cap_neg;
  logic [62:0]          iterm_sat;

  // Four products of at most 33 by 26 bits.
  assign p_prod  = $signed(err_b) * $signed({1'b0, gain_p});
  assign d_prod  = $signed(diff_b) * $signed({1'b0, gain_d});
  assign lo_prod = sum_b[31:0] * gain_i;
  assign hi_prod = $signed(sum_b[SUM_WIDTH-1:32]) * $signed({1'b0, gain_i});

  always_ff @(posedge clk) begin
    if (adv.c) begin
      p_c   <= p_prod;
      d_c   <= d_prod;
      lo_c  <= lo_prod;
      hi_c  <= hi_prod;
      err_c <= err_b;
    end
  end

  // Rejoin the integral product and saturate it at plus or minus 2^61.
  assign full_i  = $signed({hi_c, 32'd0}) + $signed({{(FULL_W - LO_W){1'b0}}, lo_c});
  assign cap_pos = $signed({{(FULL_W - 62){1'b0}}, 1'b1, 61'd0});
  assign cap_neg = -cap_pos;
  always_comb begin
    if (full_i > cap_pos) begin
      iterm_sat = {2'b01, 61'd0};
    end else if (full_i < cap_neg) begin
      iterm_sat = {2'b11, 61'd0};
    end else begin
      iterm_sat = full_i[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.d) begin
      iterm_d <= iterm_sat;
      pd_d    <= {{2{p_c[57]}}, p_c} + {d_c[58], d_c};
      err_d   <= err_c;
    end
  end

endmodule

`default_nettype wire

[rtl/pdw_out.sv]
// Final sum, rounding to Q.16 and the symmetric output clamp.
`timescale 1ns / 1ps
`default_nettype none

module pdw_out (
  input  wire                         clk,
  input  pdw_pkg::pdw_adv_t           adv,
  input  wire  [pdw_pkg::LIMIT_W-1:0] output_limit,
  input  wire  [62:0]                 iterm_d,
  input  wire  [59:0]                 pd_d,
  input  wire  [31:0]                 err_d,
  output logic [31:0]                 drive,
  output logic [31:0]                 error_used,
  output logic                        clamped
);
  import pdw_pkg::*;

  logic [63:0]        total;
  logic signed [47:0] rounded;
  logic signed [47:0] lim_pos;
  logic signed [47:0] lim_neg;
  logic [31:0]        drive_next;
  logic               clamped_next;

  // Sum the terms with the rounding offset, then floor to Q.16.
  assign total   = {{4{pd_d[59]}}, pd_d} + {iterm_d[62], iterm_d} + ROUND_HALF;
  assign rounded = $signed(total[63:16]);

  // Values exactly at the limit pass unclamped.
  assign lim_pos = $signed({17'd0, output_limit});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (rounded > lim_pos) begin
      drive_next   = lim_pos[31:0];
      clamped_next = 1'b1;
    end else if (rounded < lim_neg) begin
      drive_next   = lim_neg[31:0];
      clamped_next = 1'b1;
    end else begin
      drive_next   = rounded[31:0];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.e) begin
      drive      <= drive_next;
      error_used <= err_d;
      clamped    <= clamped_next;
    end
  end

endmodule

`default_nettype wire

[rtl/positional_pid_deadband_wrap.sv]
// Top level of the positional PID controller with deadband, angle fold and clamp.
//
// Usage: an input item (setpoint, measured) is taken at a clock edge where
// in_valid is high and in_stall is low. Each item yields exactly one result
// item (drive, error_used, clamped), offered with out_valid and taken when
// out_stall is low. Gains, deadband, output limit and wrap enable are written
// on the cfg channel (cfg_ready is always high) while no item is in flight.
// An accepted item passes five registers: error and fold, deadband and integral
// state, products, integral saturation, rounding and clamp; out_valid is high
// while the last of them holds an item.
// Throughput is one item per cycle while out_stall is low.
// The integral and previous error update in the second stage, so items that
// follow back to back see the state of the item before them.
// When out_stall is high, the result register holds and the stages before it
// keep filling until each holds an item; in_stall rises only once all five
// are occupied. Reset clears the pipeline valids, the integral and the
// previous error, and loads the registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_deadband_wrap #(
  parameter int unsigned SUM_WIDTH = 48
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] setpoint,
  input  wire  [31:0] measured,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] drive,
  output logic [31:0] error_used,
  output logic        clamped,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import pdw_pkg::*;

  logic [GAIN_W-1:0]  gain_p;
  logic [GAIN_W-1:0]  gain_i;
  logic [GAIN_W-1:0]  gain_d;
  logic [DB_W-1:0]    deadband;
  logic [LIMIT_W-1:0] output_limit;
  logic               wrap_enable;

  logic v_a, v_b, v_c, v_d, v_e;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  pdw_adv_t adv;

  logic [31:0]          err_b;
  logic [SUM_WIDTH-1:0] sum_b;
  logic [32:0]          diff_b;
  logic [62:0]          iterm_d;
  logic [59:0]          pd_d;
  logic [31:0]          err_d;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= RST_GAIN_P;
      gain_i       <= RST_GAIN_I;
      gain_d       <= RST_GAIN_D;
      deadband     <= RST_DEADBAND;
      output_limit <= RST_OUTPUT_LIMIT;
      wrap_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GAIN_P:       gain_p       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:       gain_i       <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:       gain_d       <= cfg_data[GAIN_W-1:0];
        CFG_DEADBAND:     deadband     <= cfg_data[DB_W-1:0];
        CFG_OUTPUT_LIMIT: output_limit <= cfg_data[LIMIT_W-1:0];
        CFG_WRAP_ENABLE:  wrap_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its item moves on.
  assign rdy_e = !v_e || !out_stall;
  assign rdy_d = !v_d || rdy_e;
  assign rdy_c = !v_c || rdy_d;
  assign rdy_b = !v_b || rdy_c;
  assign rdy_a = !v_a || rdy_b;

  assign in_stall = !rdy_a;
  assign adv.a = in_valid && rdy_a;
  assign adv.b = v_a && rdy_b;
  assign adv.c = v_b && rdy_c;
  assign adv.d = v_c && rdy_d;
  assign adv.e = v_d && rdy_e;

  // Pipeline occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else begin
      if (rdy_a) v_a <= in_valid;
      if (rdy_b) v_b <= v_a;
      if (rdy_c) v_c <= v_b;
      if (rdy_d) v_d <= v_c;
      if (rdy_e) v_e <= v_d;
    end
  end

  assign out_valid = v_e;

  pdw_err #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_err (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .setpoint   (setpoint),
    .measured   (measured),
    .wrap_enable(wrap_enable),
    .deadband   (deadband),
    .err_b      (err_b),
    .sum_b      (sum_b),
    .diff_b     (diff_b)
  );

  pdw_mult #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_mult (
    .clk    (clk),
    .adv    (adv),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .err_b  (err_b),
    .sum_b  (sum_b),
    .diff_b (diff_b),
    .iterm_d(iterm_d),
    .pd_d   (pd_d),
    .err_d  (err_d)
  );

  pdw_out u_out (
    .clk         (clk),
    .adv         (adv),
    .output_limit(output_limit),
    .iterm_d     (iterm_d),
    .pd_d        (pd_d),
    .err_d       (err_d),
    .drive       (drive),
    .error_used  (error_used),
    .clamped     (clamped)
  );

endmodule

`default_nettype wire
